// ===== rtl/sorted_key_index_count_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted key index count core
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_INDEX_COUNT_CORE_MACROS_SVH
`define SORTED_KEY_INDEX_COUNT_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define SKIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define SKIC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define SKIC_ASSERT(lbl, prop, msg)
`define SKIC_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== rtl/skic_pkg.sv =====
// ----------------------------------------------------------------------------
// skic_pkg
// Item types, codes and controller/datapath command types.
// ----------------------------------------------------------------------------
`default_nettype none

package skic_pkg;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_COUNT = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [1:0] COL_FIRST  = 2'd1;
  localparam logic [1:0] COL_SECOND = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_COL = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_RANGE   = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         column;
    logic signed [31:0] key_value;
    logic [11:0]        position;
    logic               load_last;
  } in_item_t;

  typedef struct packed {
    logic [12:0]        match_count;
    logic signed [31:0] read_value;
    logic [12:0]        table_size;
    logic [1:0]         status;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_DISPATCH,
    OP_RWAIT,
    OP_SRCH,
    OP_SWAIT,
    OP_COPY_RD,
    OP_COPY_WR,
    OP_BUB_RD0,
    OP_BUB_LD0,
    OP_BUB_RD,
    OP_BUB_CMP,
    OP_BUB_END,
    OP_PUBLISH
  } op_e;

  typedef struct packed {
    logic go_read;
    logic go_search;
    logic go_copy;
    logic srch_open;
    logic srch_upper;
    logic copy_done;
    logic bub_small;
    logic bub_pass_end;
    logic bub_again;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/skic_datapath.sv =====
// ----------------------------------------------------------------------------
// skic_datapath
// Key and index memories, column lengths, search bounds, sort registers and
// the output register. Every step is ordered by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_index_count_core_macros.svh"

module skic_datapath #(
  parameter int ROW_DEPTH = 4096,
  parameter int KEY_BITS  = 32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  skic_pkg::op_e         cmd_i,
  input  skic_pkg::in_item_t    in_item_i,
  input  wire                   out_stall_i,
  output logic                  out_valid_o,
  output skic_pkg::out_item_t   out_item_o,
  output skic_pkg::dp_status_t  status_o
);
  import skic_pkg::*;

  localparam int AW = $clog2(ROW_DEPTH);
  localparam int LW = $clog2(ROW_DEPTH + 1);
  localparam int PW = 12;
  localparam logic [KEY_BITS-1:0] KEY_SIGN = {1'b1, {(KEY_BITS-1){1'b0}}};
  localparam logic [LW-1:0] DEPTH_L = LW'(ROW_DEPTH);

  logic [KEY_BITS-1:0] key_mem [0:(2 << AW)-1];
  logic [KEY_BITS-1:0] idx_mem [0:(2 << AW)-1];

  in_item_t            item_q;
  logic [LW-1:0]       len_q [2];
  logic [LW-1:0]       icnt_q [2];
  logic [LW-1:0]       lo_q, hi_q, mid_q, lob_q, cnt_q, end_q;
  logic                upper_q, swap_q, out_valid_q;
  logic [KEY_BITS-1:0] cur_q, key_rd_q, idx_rd_q;
  logic [12:0]         match_q;
  logic [31:0]         readv_q;
  logic [1:0]          status_q;
  out_item_t           out_q;

  logic                sel, col_ok, bad, pos_ok, has_room;
  logic [LW-1:0]       cur_len, cur_icnt, new_len, mid_c, cnt_prev, end_prev, size_c;
  logic [LW+PW-1:0]    pos_ext, len_ext;
  logic [KEY_BITS-1:0] key_k, key_b, rd_unb, cmp_x;
  logic [31:0]         readback;
  logic [LW+12:0]      match_w, size_w;
  logic                below;

  assign sel      = (item_q.column == COL_SECOND);
  assign col_ok   = (item_q.column == COL_FIRST) || (item_q.column == COL_SECOND);
  assign bad      = (item_q.kind != KIND_SPARE) && !col_ok;
  assign cur_len  = len_q[sel];
  assign cur_icnt = icnt_q[sel];
  assign has_room = cur_len < DEPTH_L;
  assign new_len  = has_room ? cur_len + LW'(1) : cur_len;
  assign pos_ext  = {{LW{1'b0}}, item_q.position};
  assign len_ext  = {{PW{1'b0}}, cur_len};
  assign pos_ok   = pos_ext < len_ext;
  assign mid_c    = lo_q + ((hi_q - lo_q) >> 1);
  assign cnt_prev = cnt_q - LW'(1);
  assign end_prev = end_q - LW'(1);
  assign size_c   = (len_q[0] > len_q[1]) ? len_q[0] : len_q[1];
  assign size_w   = {13'd0, size_c};
  assign match_w  = {13'd0, lo_q - lob_q};

  generate
    if (KEY_BITS > 32) begin : g_key_wide
      assign key_k = {{(KEY_BITS-32){item_q.key_value[31]}}, item_q.key_value};
    end else begin : g_key_narrow
      assign key_k = item_q.key_value[KEY_BITS-1:0];
    end
  endgenerate
  assign key_b  = key_k ^ KEY_SIGN;
  assign rd_unb = key_rd_q ^ KEY_SIGN;

  generate
    if (KEY_BITS < 32) begin : g_rd_narrow
      assign readback = {{(32-KEY_BITS){rd_unb[KEY_BITS-1]}}, rd_unb};
    end else begin : g_rd_wide
      assign readback = rd_unb[31:0];
    end
  endgenerate

  assign below = upper_q ? (idx_rd_q <= key_b) : (idx_rd_q < key_b);
  assign cmp_x = idx_rd_q;

  // key memory: append on load, read for reads and index copy
  always_ff @(posedge clk_i) begin
    if (cmd_i == OP_DISPATCH && !bad && item_q.kind == KIND_LOAD && has_room) begin
      key_mem[{sel, cur_len[AW-1:0]}] <= key_b;
    end
    if (cmd_i == OP_DISPATCH) begin
      key_rd_q <= key_mem[{sel, pos_ext[AW-1:0]}];
    end else if (cmd_i == OP_COPY_RD) begin
      key_rd_q <= key_mem[{sel, cnt_q[AW-1:0]}];
    end
  end

  // index memory: one write and one read port
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      OP_COPY_WR: idx_mem[{sel, cnt_q[AW-1:0]}] <= key_rd_q;
      OP_BUB_CMP: idx_mem[{sel, cnt_prev[AW-1:0]}] <= (cmp_x < cur_q) ? cmp_x : cur_q;
      OP_BUB_END: idx_mem[{sel, end_prev[AW-1:0]}] <= cur_q;
      default: ;
    endcase
    unique case (cmd_i)
      OP_SRCH:    idx_rd_q <= idx_mem[{sel, mid_c[AW-1:0]}];
      OP_BUB_RD0: idx_rd_q <= idx_mem[{sel, {AW{1'b0}}}];
      OP_BUB_RD:  idx_rd_q <= idx_mem[{sel, cnt_q[AW-1:0]}];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q[0]    <= '0;
      len_q[1]    <= '0;
      icnt_q[0]   <= '0;
      icnt_q[1]   <= '0;
      upper_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i == OP_PUBLISH) out_valid_q <= 1'b1;
      else if (!out_stall_i)   out_valid_q <= 1'b0;
      if (cmd_i == OP_DISPATCH && !bad && item_q.kind == KIND_LOAD) begin
        len_q[sel] <= new_len;
        if (item_q.load_last) icnt_q[sel] <= new_len;
      end
      if (cmd_i == OP_DISPATCH) upper_q <= 1'b0;
      if (cmd_i == OP_SRCH && !(lo_q < hi_q)) upper_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      OP_LATCH: begin
        item_q   <= in_item_i;
        match_q  <= '0;
        readv_q  <= '0;
        status_q <= STATUS_OK;
      end
      OP_DISPATCH: begin
        lo_q  <= '0;
        hi_q  <= cur_icnt;
        cnt_q <= '0;
        end_q <= new_len;
        if (bad) begin
          status_q <= STATUS_BAD_COL;
        end else if (item_q.kind == KIND_LOAD && !has_room) begin
          status_q <= STATUS_FULL;
        end else if (item_q.kind == KIND_READ && !pos_ok) begin
          status_q <= STATUS_RANGE;
        end
      end
      OP_RWAIT: readv_q <= readback;
      OP_SRCH: begin
        if (lo_q < hi_q) begin
          mid_q <= mid_c;
        end else if (!upper_q) begin
          lob_q <= lo_q;
          lo_q  <= '0;
          hi_q  <= cur_icnt;
        end else begin
          match_q <= match_w[12:0];
        end
      end
      OP_SWAIT: begin
        if (below) lo_q <= mid_q + LW'(1);
        else       hi_q <= mid_q;
      end
      OP_COPY_WR: cnt_q <= cnt_q + LW'(1);
      OP_BUB_RD0: swap_q <= 1'b0;
      OP_BUB_LD0: begin
        cur_q <= idx_rd_q;
        cnt_q <= LW'(1);
      end
      OP_BUB_CMP: begin
        // keep the larger key moving up; the smaller one drops behind
        if (cmp_x < cur_q) swap_q <= 1'b1;
        else               cur_q  <= cmp_x;
        cnt_q <= cnt_q + LW'(1);
      end
      OP_BUB_END: end_q <= end_prev;
      OP_PUBLISH: begin
        out_q.match_count <= match_q;
        out_q.read_value  <= readv_q;
        out_q.table_size  <= size_w[12:0];
        out_q.status      <= status_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    status_o              = '0;
    status_o.go_read      = !bad && item_q.kind == KIND_READ && pos_ok;
    status_o.go_search    = !bad && item_q.kind == KIND_COUNT;
    status_o.go_copy      = !bad && item_q.kind == KIND_LOAD && item_q.load_last;
    status_o.srch_open    = lo_q < hi_q;
    status_o.srch_upper   = upper_q;
    status_o.copy_done    = cnt_q == end_q;
    status_o.bub_small    = end_q <= LW'(1);
    status_o.bub_pass_end = (cnt_q + LW'(1)) == end_q;
    status_o.bub_again    = swap_q && (end_q > LW'(2));
    status_o.out_free     = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `SKIC_ASSERT(a_len_bound, (len_q[0] <= DEPTH_L) && (len_q[1] <= DEPTH_L), "length overflow")
  `SKIC_ASSERT(a_icnt_bound, (icnt_q[0] <= len_q[0]) && (icnt_q[1] <= len_q[1]), "icnt high")
  `SKIC_ASSERT_NEXT(a_publish, cmd_i == OP_PUBLISH, out_valid_q, "publish did not raise valid")

endmodule

`default_nettype wire

// ===== rtl/skic_ctrl.sv =====
// ----------------------------------------------------------------------------
// skic_ctrl
// Sequencer: takes one item, steps the datapath through load, read, the two
// binary searches or the copy and bubble sort, then hands the result over.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_index_count_core_macros.svh"

module skic_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  skic_pkg::dp_status_t  status_i,
  output skic_pkg::op_e         cmd_o
);
  import skic_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_RWAIT = 4'd2;
  localparam logic [3:0] S_SRCH  = 4'd3;
  localparam logic [3:0] S_SWAIT = 4'd4;
  localparam logic [3:0] S_COPY  = 4'd5;
  localparam logic [3:0] S_COPYW = 4'd6;
  localparam logic [3:0] S_BSTRT = 4'd7;
  localparam logic [3:0] S_BRD0  = 4'd8;
  localparam logic [3:0] S_BLD0  = 4'd9;
  localparam logic [3:0] S_BRD   = 4'd10;
  localparam logic [3:0] S_BCMP  = 4'd11;
  localparam logic [3:0] S_BEND  = 4'd12;
  localparam logic [3:0] S_FIN   = 4'd13;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = OP_LATCH;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        cmd_o = OP_DISPATCH;
        priority if (status_i.go_read)   state_d = S_RWAIT;
        else if (status_i.go_search)     state_d = S_SRCH;
        else if (status_i.go_copy)       state_d = S_COPY;
        else                             state_d = S_FIN;
      end
      S_RWAIT: begin
        cmd_o   = OP_RWAIT;
        state_d = S_FIN;
      end
      S_SRCH: begin
        cmd_o = OP_SRCH;
        priority if (status_i.srch_open) state_d = S_SWAIT;
        else if (status_i.srch_upper)    state_d = S_FIN;
        else                             state_d = S_SRCH;
      end
      S_SWAIT: begin
        cmd_o   = OP_SWAIT;
        state_d = S_SRCH;
      end
      S_COPY: begin
        if (status_i.copy_done) begin
          state_d = S_BSTRT;
        end else begin
          cmd_o   = OP_COPY_RD;
          state_d = S_COPYW;
        end
      end
      S_COPYW: begin
        cmd_o   = OP_COPY_WR;
        state_d = S_COPY;
      end
      S_BSTRT: state_d = status_i.bub_small ? S_FIN : S_BRD0;
      S_BRD0: begin
        cmd_o   = OP_BUB_RD0;
        state_d = S_BLD0;
      end
      S_BLD0: begin
        cmd_o   = OP_BUB_LD0;
        state_d = S_BRD;
      end
      S_BRD: begin
        cmd_o   = OP_BUB_RD;
        state_d = S_BCMP;
      end
      S_BCMP: begin
        cmd_o   = OP_BUB_CMP;
        state_d = status_i.bub_pass_end ? S_BEND : S_BRD;
      end
      S_BEND: begin
        cmd_o   = OP_BUB_END;
        state_d = status_i.bub_again ? S_BRD0 : S_FIN;
      end
      S_FIN: begin
        // hold the result until the output register is free
        if (status_i.out_free) begin
          cmd_o   = OP_PUBLISH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  `SKIC_ASSERT_NEXT(a_take, (state_q == S_IDLE) && in_valid_i, state_q == S_DISP, "no dispatch")

endmodule

`default_nettype wire

// ===== rtl/sorted_key_index_count_core.sv =====
// From acceptance to a valid result: a load passes dispatch and finish; a read adds
// a memory wait; a count runs two binary searches of search and wait probes.
// A last load adds a copy of the column into its index and a bubble sort of it.
// Throughput: one item at a time; the next is accepted in the cycle after the result
// is handed over, even while that result still waits.
// Reset: lengths and index counts clear at once; memories are not cleared.
// ----------------------------------------------------------------------------
// sorted_key_index_count_core
// Two-column key table with sorted index rebuild and equal-range count.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_index_count_core #(
  parameter int ROW_DEPTH = 4096,
  parameter int KEY_BITS  = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  skic_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output skic_pkg::out_item_t  out_item_o
);
  import skic_pkg::*;

  op_e        cmd;
  dp_status_t dp_status;

  skic_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (dp_status),
    .cmd_o      (cmd)
  );

  skic_datapath #(
    .ROW_DEPTH (ROW_DEPTH),
    .KEY_BITS  (KEY_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .status_o    (dp_status)
  );

endmodule

`default_nettype wire

// ===== test/tb_sorted_key_index_count_core.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_key_index_count_core
// Self-checking test of the two-column key table: loads, index rebuilds,
// equal-key counts and raw reads, with random idle and stall bursts.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_key_index_count_core;
  import skic_pkg::*;

  localparam int DEPTH      = 4096;
  localparam int SMALL_ROWS = 70;
  localparam int MAX_CYCLES = 6000000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  sorted_key_index_count_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // table state as the block should hold it; index 0 is column 1
  int        column_keys[2][$];
  int        sorted_keys[2][$];
  out_item_t pending_results[$];
  bit        calm = 1'b0;
  int        mismatches = 0;
  int        results_seen = 0;
  int        rebuilds = 0;
  int        cycles = 0;
  int        key_pool[8];

  function automatic out_item_t table_apply(in_item_t it);
    out_item_t r;
    int        c;
    int        n;
    r = '0;
    c = (it.column == COL_SECOND) ? 1 : 0;
    if (it.kind != KIND_SPARE && it.column != COL_FIRST && it.column != COL_SECOND) begin
      r.status = STATUS_BAD_COL;
    end else if (it.kind == KIND_LOAD) begin
      if (column_keys[c].size() < DEPTH) column_keys[c] = {column_keys[c], it.key_value};
      else r.status = STATUS_FULL;
      if (it.load_last) begin
        sorted_keys[c] = column_keys[c];
        sorted_keys[c].sort();
        rebuilds++;
      end
    end else if (it.kind == KIND_COUNT) begin
      n = 0;
      for (int i = 0; i < sorted_keys[c].size(); i++)
        if (sorted_keys[c][i] == it.key_value) n++;
      r.match_count = 13'(n);
    end else if (it.kind == KIND_READ) begin
      if (it.position < column_keys[c].size()) r.read_value = column_keys[c][it.position];
      else r.status = STATUS_RANGE;
    end
    r.table_size = 13'((column_keys[0].size() > column_keys[1].size()) ?
                       column_keys[0].size() : column_keys[1].size());
    return r;
  endfunction

  task automatic send_item(logic [1:0] kind, logic [1:0] column, int key,
                           logic [11:0] position, logic last);
    in_item_t it;
    it = '{kind: kind, column: column, key_value: key, position: position, load_last: last};
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    pending_results = {pending_results, table_apply(it)};
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // receiver stall bursts
  initial begin
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_item_o);
      end else begin
        out_item_t want;
        want = pending_results.pop_front();
        if (out_item_o.match_count !== want.match_count ||
            out_item_o.read_value !== want.read_value ||
            out_item_o.table_size !== want.table_size ||
            out_item_o.status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, got %p", want, out_item_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic test_empty_table();
    send_item(KIND_COUNT, COL_FIRST, 0, 0, 1'b0);
    send_item(KIND_COUNT, COL_SECOND, -1, 0, 1'b0);
    send_item(KIND_READ, COL_FIRST, 0, 0, 1'b0);
    send_item(KIND_READ, COL_SECOND, 0, 12'hfff, 1'b0);
    for (int k = 0; k < 4; k++) begin
      send_item(k[1:0], 2'd0, 5, 0, 1'b1);
      send_item(k[1:0], 2'd3, -5, 0, 1'b0);
    end
  endtask

  task automatic test_extreme_keys();
    send_item(KIND_LOAD, COL_FIRST, 32'sh8000_0000, 0, 1'b0);
    send_item(KIND_LOAD, COL_FIRST, 32'sh7fff_ffff, 0, 1'b0);
    send_item(KIND_LOAD, COL_FIRST, 0, 0, 1'b0);
    send_item(KIND_LOAD, COL_FIRST, -1, 0, 1'b0);
    send_item(KIND_COUNT, COL_FIRST, -1, 0, 1'b0);  // index not rebuilt yet
    send_item(KIND_LOAD, COL_FIRST, 32'sh7fff_ffff, 0, 1'b1);
    send_item(KIND_COUNT, COL_FIRST, 32'sh7fff_ffff, 0, 1'b0);
    send_item(KIND_COUNT, COL_FIRST, 32'sh8000_0000, 0, 1'b0);
    send_item(KIND_COUNT, COL_FIRST, 1, 0, 1'b0);
    send_item(KIND_READ, COL_FIRST, 0, 0, 1'b0);
    send_item(KIND_READ, COL_FIRST, 0, 4, 1'b0);
    send_item(KIND_READ, COL_FIRST, 0, 5, 1'b0);
    send_item(KIND_LOAD, COL_SECOND, -7, 0, 1'b1);
    send_item(KIND_LOAD, COL_SECOND, -7, 0, 1'b0);
    send_item(KIND_COUNT, COL_SECOND, -7, 0, 1'b0);  // sees the older index
  endtask

  task automatic test_random_traffic(int items);
    int          c;
    int          len;
    int          key;
    logic [11:0] pos;
    for (int i = 0; i < items; i++) begin
      if (i > items - 150) calm = 1'b1;
      c   = $urandom_range(0, 1);
      len = column_keys[c].size();
      key = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[$urandom_range(0, 7)];
      pos = ($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom_range(0, len));
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          if (len < SMALL_ROWS)
            send_item(KIND_LOAD, c ? COL_SECOND : COL_FIRST, key, 12'($urandom),
                      $urandom_range(0, 11) == 0);
          else
            send_item(KIND_COUNT, c ? COL_SECOND : COL_FIRST, key, 12'($urandom), 1'b0);
        end
        3, 4, 5: send_item(KIND_COUNT, c ? COL_SECOND : COL_FIRST, key, pos, 1'($urandom));
        6, 7:    send_item(KIND_READ, c ? COL_SECOND : COL_FIRST, key, pos, 1'($urandom));
        default: send_item(2'($urandom), ($urandom_range(0, 1) ? 2'd0 : 2'd3), key, pos,
                           1'b0);
      endcase
    end
  endtask

  initial begin
    foreach (key_pool[i]) key_pool[i] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3);
    key_pool[0] = 32'sh8000_0000;
    key_pool[1] = 32'sh7fff_ffff;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_extreme_keys();
    test_random_traffic(1400);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("checked %0d results over %0d index rebuilds, with bad columns,", results_seen,
             rebuilds);
    $display("spare kinds and out-of-range reads mixed in, %0d mismatches", mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
